// ----- src/cppc_pkg.sv -----
// cppc_pkg: shared types and constants for the close pair point classifier
// used by cppc_ctrl, cppc_dp and close_pair_point_classifier
`timescale 1ns / 1ps
`default_nettype none

package cppc_pkg;

    localparam int DEF_MAX_POINTS  = 256;
    localparam int DEF_COORD_WIDTH = 16;
    localparam int RADIUS_W        = 16;
    localparam int R2_W            = 2 * RADIUS_W;
    localparam int OUT_CNT_W       = 9;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pair_init;
        logic pair_step;
        logic cnt_init;
        logic cnt_step;
        logic publish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pair_none;
        logic pair_last;
        logic pipe_empty;
        logic cnt_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- src/cppc_dp.sv -----
// cppc_dp: point stores, pair index counters, compare pipeline, close flags,
// count sweep and result register; depends on cppc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cppc_dp #(
    parameter int MAX_POINTS  = cppc_pkg::DEF_MAX_POINTS,
    parameter int COORD_WIDTH = cppc_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire cppc_pkg::t_cmd                      i_cmd,
    output cppc_pkg::t_sts                           o_sts,
    input  wire logic                                i_cfg_we,
    input  wire logic [cppc_pkg::RADIUS_W-1:0]       i_cfg_data,
    input  wire logic signed [COORD_WIDTH-1:0]       i_x_coord,
    input  wire logic signed [COORD_WIDTH-1:0]       i_y_coord,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [cppc_pkg::OUT_CNT_W-1:0]           o_close_count,
    output logic [cppc_pkg::OUT_CNT_W-1:0]           o_lone_count,
    output logic                                     o_overflow
);
    import cppc_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int SQ_W  = 2 * W;
    localparam int SUM_W = (SQ_W + 1 > R2_W) ? SQ_W + 1 : R2_W;

    // configuration
    logic [RADIUS_W-1:0] r_radius;
    logic [R2_W-1:0]     r_r2;

    // point stores
    logic [W-1:0] r_mem_x [MAX_POINTS];
    logic [W-1:0] r_mem_y [MAX_POINTS];

    // set bookkeeping
    logic [CW-1:0]         r_cnt;
    logic                  r_dropped;
    logic [MAX_POINTS-1:0] r_flags;

    // pair counters
    logic [AW-1:0] r_pi;
    logic [AW-1:0] r_pj;

    // compare pipeline
    logic          r_v1, r_v2, r_v3;
    logic [AW-1:0] r_i1, r_j1, r_i2, r_j2, r_i3, r_j3;
    logic [W-1:0]  r_xi, r_yi, r_xj, r_yj;
    logic [W-1:0]  r_dx, r_dy;
    logic [SQ_W-1:0] r_sqx, r_sqy;
    logic          r_far;

    // count sweep
    logic [AW-1:0] r_k;
    logic [CW-1:0] r_close;

    // result register
    logic                 r_out_valid;
    logic [OUT_CNT_W-1:0] r_close_out;
    logic [OUT_CNT_W-1:0] r_lone_out;
    logic                 r_ovf;

    logic signed [W:0] xi_e, xj_e, yi_e, yj_e;
    logic [W-1:0]      n_dx, n_dy;
    logic [63:0]       dx_e, dy_e;
    logic [SUM_W-1:0]  sum3;
    logic              close3;
    logic              store_room;
    logic              pj_end;

    assign store_room = (r_cnt < CW'(MAX_POINTS));
    assign pj_end     = (CW'(r_pj) == r_cnt - CW'(1));

    // absolute differences
    always_comb begin
        xi_e = {r_xi[W-1], r_xi};
        xj_e = {r_xj[W-1], r_xj};
        yi_e = {r_yi[W-1], r_yi};
        yj_e = {r_yj[W-1], r_yj};
        n_dx = (xi_e >= xj_e) ? W'(xi_e - xj_e) : W'(xj_e - xi_e);
        n_dy = (yi_e >= yj_e) ? W'(yi_e - yj_e) : W'(yj_e - yi_e);
        dx_e = 64'(r_dx);
        dy_e = 64'(r_dy);
    end

    assign sum3   = SUM_W'(r_sqx) + SUM_W'(r_sqy);
    assign close3 = !r_far && (sum3 < SUM_W'(r_r2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_r2     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
            r_r2 <= r_radius * r_radius;
        end
    end

    // store write and dual read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && store_room) begin
            r_mem_x[r_cnt[AW-1:0]] <= i_x_coord;
            r_mem_y[r_cnt[AW-1:0]] <= i_y_coord;
        end
        r_xi <= r_mem_x[r_pi];
        r_yi <= r_mem_y[r_pi];
        r_xj <= r_mem_x[r_pj];
        r_yj <= r_mem_y[r_pj];
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_i1  <= r_pi;
        r_j1  <= r_pj;
        r_i2  <= r_i1;
        r_j2  <= r_j1;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_i3  <= r_i2;
        r_j3  <= r_j2;
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
        r_far <= (|dx_e[63:31]) || (|dy_e[63:31]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.pair_step;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // pair index sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pi <= '0;
            r_pj <= '0;
        end else if (i_cmd.pair_init) begin
            r_pi <= '0;
            r_pj <= AW'(1);
        end else if (i_cmd.pair_step) begin
            if (pj_end) begin
                r_pi <= r_pi + AW'(1);
                r_pj <= AW'(CW'(r_pi) + CW'(2));
            end else begin
                r_pj <= r_pj + AW'(1);
            end
        end
    end

    // set state, flags and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_dropped   <= 1'b0;
            r_flags     <= '0;
            r_k         <= '0;
            r_close     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (store_room) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            // the count sweep clears each flag as it reads it
            if (i_cmd.cnt_step) begin
                r_flags[r_k] <= 1'b0;
            end else if (r_v3 && close3) begin
                r_flags[r_i3] <= 1'b1;
                r_flags[r_j3] <= 1'b1;
            end
            if (i_cmd.cnt_init) begin
                r_k     <= '0;
                r_close <= '0;
            end else if (i_cmd.cnt_step) begin
                r_k     <= r_k + AW'(1);
                r_close <= r_close + CW'(r_flags[r_k]);
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
                r_cnt       <= '0;
                r_dropped   <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_close_out <= OUT_CNT_W'(r_close);
            r_lone_out  <= OUT_CNT_W'(r_cnt - r_close);
            r_ovf       <= r_dropped;
        end
    end

    always_comb begin
        o_sts.pair_none  = (r_cnt < CW'(2));
        o_sts.pair_last  = (CW'(r_pi) == r_cnt - CW'(2)) && pj_end;
        o_sts.pipe_empty = !(r_v1 || r_v2 || r_v3);
        o_sts.cnt_last   = (CW'(r_k) == r_cnt - CW'(1));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_close_count = r_close_out;
    assign o_lone_count  = r_lone_out;
    assign o_overflow    = r_ovf;

endmodule

`default_nettype wire

// ----- src/cppc_ctrl.sv -----
// cppc_ctrl: sequencer for load, pair compare, drain, count and publish
// depends on cppc_pkg command and status types
`timescale 1ns / 1ps
`default_nettype none

module cppc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_last_point,
    output logic                o_in_ready,
    input  wire cppc_pkg::t_sts i_sts,
    output cppc_pkg::t_cmd      o_cmd
);
    import cppc_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_PAIR  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_COUNT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_last_point) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.pair_init = 1'b1;
                o_cmd.cnt_init  = 1'b1;
                n_state = i_sts.pair_none ? ST_COUNT : ST_PAIR;
            end
            ST_PAIR: begin
                o_cmd.pair_step = 1'b1;
                if (i_sts.pair_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                o_cmd.cnt_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- src/close_pair_point_classifier.sv -----
// close pair point classifier top level: controller plus datapath
// after the closing request of a set of stored points the datapath compares every pair, drains the
// compare pipe, counts flagged points and publishes; one pair per cycle through the compare pipe
// no new points are taken while a set is processed; throughput is set by the single compare unit
// synchronous active-low reset clears control, radius, flags and counts;
// point stores and result register are not cleared
`timescale 1ns / 1ps
`default_nettype none

module close_pair_point_classifier #(
    parameter int MAX_POINTS  = cppc_pkg::DEF_MAX_POINTS,
    parameter int COORD_WIDTH = cppc_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cppc_pkg::RADIUS_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  wire logic                          i_last_point,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [cppc_pkg::OUT_CNT_W-1:0]     o_close_count,
    output logic [cppc_pkg::OUT_CNT_W-1:0]     o_lone_count,
    output logic                               o_overflow
);
    import cppc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cppc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_point (i_last_point),
        .o_in_ready   (o_in_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    cppc_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_close_count (o_close_count),
        .o_lone_count  (o_lone_count),
        .o_overflow    (o_overflow)
    );

    // result only published into a free output register
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> sts.out_free)
        else $error("publish while output register busy");

    // no compare still in flight when the count sweep runs
    a_count_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_step |-> sts.pipe_empty)
        else $error("count sweep with compares in flight");

    // loading never overlaps the compare or count phases
    a_load_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !(cmd.pair_step || cmd.cnt_step || cmd.publish))
        else $error("load overlaps processing");

    // a published result is offered on the next cycle
    a_publish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |=> o_out_valid)
        else $error("published result not offered");

endmodule

`default_nettype wire
